/* hw/rtl/osc_pkg.sv */
// Shared types, constants and helper functions for the overdrive soft clip core.
// Used by the top level, the shared multiplier and the iterative divider.
// No dependencies.
package osc_pkg;

  // Field and state widths
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned COEF_W    = 25;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LPI_W     = 48;
  localparam int unsigned HPO_W     = 49;
  localparam int unsigned LPO_W     = 56;
  localparam int unsigned OPND_W    = 57;
  localparam int unsigned RMAG_W    = 67;
  localparam int unsigned RES_W     = 68;
  localparam int unsigned WIDE_W    = 70;

  // Shared multiplier and divider widths
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned DVD_W  = 51;
  localparam int unsigned DEN_W  = 33;

  // Register indexes on the config channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LP_IN  = 3'd0,
    REG_HP_IN  = 3'd1,
    REG_LP_OUT = 3'd2,
    REG_GAIN   = 3'd3,
    REG_KNEE   = 3'd4,
    REG_OFFSET = 3'd5
  } osc_reg_e;

  // Reset values of the config registers
  localparam logic [COEF_W-1:0]        RST_LP_IN  = 25'd633950;
  localparam logic [COEF_W-1:0]        RST_HP_IN  = 25'd7266030;
  localparam logic [COEF_W-1:0]        RST_LP_OUT = 25'd9511100;
  localparam logic [GAIN_W-1:0]        RST_GAIN   = 24'd655360;
  localparam logic signed [GAIN_W-1:0] RST_KNEE   = -24'sd13107;
  localparam logic signed [GAIN_W-1:0] RST_OFFSET = -24'sd16423;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } osc_div_stat_t;

  // floor(2^32 / k) for the Horner divide-by-k steps (k = 1..6)
  function automatic logic [MUL_W-1:0] recip(input logic [2:0] k);
    logic [MUL_W-1:0] r;
    case (k)
      3'd2:    r = 33'd2147483648;
      3'd3:    r = 33'd1431655765;
      3'd4:    r = 33'd1073741824;
      3'd5:    r = 33'd858993459;
      3'd6:    r = 33'd715827882;
      default: r = 33'd4294967296;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to a signed range of the given width
  function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v,
                                                        input int unsigned bits);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed((WIDE_W'(1) << (bits - 1)) - WIDE_W'(1));
    lo = ~hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

/* hw/rtl/osc_mul.sv */
// Shared 33x33 unsigned multiplier with a registered product.
// Depends on osc_pkg.
module osc_mul import osc_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [PROD_W-1:0] p_o
);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] p_q;

  assign prod = PROD_W'(a_i) * PROD_W'(b_i);

  // product register, loaded only on a multiply step
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= prod;
    end
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/osc_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on osc_pkg.
module osc_div import osc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [DEN_W-1:0]  divisor_i,
  output osc_div_stat_t     stat_o,
  output logic [DVD_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] div_q;
  logic [DVD_W-1:0] quo_q;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_sub;

  // one shift / compare / subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[DVD_W-1]};
    ge      = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DVD_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
      rem_q  <= '0;
      div_q  <= divisor_i;
      quo_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

/* hw/rtl/overdrive_soft_clip_filter_core.sv */
// Overdrive soft clip core: input lowpass, highpass, pre-gain, soft clip, output lowpass.
// Sequencer around the shared multiplier (osc_mul) and divider (osc_div).
// Depends on osc_pkg.
//
// Usage:
//  - Samples enter on the s_axis channel (signed 32-bit in tdata), results leave on
//    m_axis (signed 32-bit, saturated to +-2147483647). One result per sample.
//  - Coefficients are written on the cfg channel (index, data); cfg_ready_o is always
//    high. Write them only while no sample is in flight.
//  - s_axis_tready is high only while the sequencer is idle; one sample is processed
//    at a time. Each coefficient product runs on the shared 33x33 multiplier in
//    steps: magnitude, two partial products, sum, sign.
//  - When the clip input is at or below the knee or at least 4.0, the soft clip
//    curve is skipped; otherwise it is evaluated in six Horner steps and eight
//    squarings on the shared multiplier, followed by a wait on the radix-2
//    divider.
//  - s_axis_tready rises again in the cycle after the result is loaded, so a new
//    sample is taken only once the previous one has been processed.
//  - A finished result sits in the output register; the next sample is accepted
//    while it waits. If the receiver stalls, the next result holds the sequencer in
//    its last step until the output register frees up.
//  - Reset restores the default coefficients and clears all filter state.
module overdrive_soft_clip_filter_core import osc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SAMPLE_W-1:0]  s_axis_tdata,   // [31:0] sample_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SAMPLE_W-1:0]  m_axis_tdata,   // [31:0] sample_out
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_MQ_ABS, ST_MQ_LO, ST_MQ_HI, ST_MQ_SUM, ST_MQ_SIGN,
    ST_LP1, ST_HP0, ST_HP1, ST_G0, ST_G1, ST_D0,
    ST_SH_INIT, ST_SH_MUL1, ST_SH_MUL2, ST_SH_DIV, ST_SH_SQ1, ST_SH_SQ2,
    ST_SH_DST, ST_SH_DW, ST_CL0, ST_CL1, ST_LO1, ST_OUT
  } state_e;

  localparam logic [DEN_W-1:0] ONE_Q32  = 33'd4294967296;
  localparam logic [DEN_W-1:0] MAX_Q32  = 33'd4294967295;
  localparam logic signed [OPND_W-1:0] SHAPE_LIM = 57'sd262144;
  localparam logic [30:0] OUT_MAX = 31'h7fffffff;

  // sequencer and config registers
  state_e state_q;
  state_e ret_q;
  logic [COEF_W-1:0]        lp_in_q;
  logic [COEF_W-1:0]        hp_in_q;
  logic [COEF_W-1:0]        lp_out_q;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [GAIN_W-1:0] knee_q;
  logic signed [GAIN_W-1:0] offset_q;

  // filter state
  logic signed [LPI_W-1:0] lpm_q;
  logic signed [LPI_W-1:0] hpi_q;
  logic signed [HPO_W-1:0] hpo_q;
  logic signed [LPO_W-1:0] lpo_q;

  // coefficient product datapath
  logic signed [OPND_W-1:0] opnd_q;
  logic [OPND_W-1:0]        mag_q;
  logic                     neg_q;
  logic [COEF_W-1:0]        coef_q;
  logic                     sh16_q;
  logic [OPND_W-1:0]        lo_q;
  logic [RMAG_W-1:0]        rmag_q;
  logic signed [RES_W-1:0]  r_q;

  // clip datapath
  logic signed [OPND_W-1:0] d_q;
  logic [OPND_W-1:0]        shp_q;
  logic signed [LPO_W-1:0]  cl_q;
  logic [28:0]              u_q;
  logic [DEN_W-1:0]         acc_q;
  logic [29:0]              t_q;
  logic [2:0]               k_q;
  logic [2:0]               i_q;

  // output register
  logic                     out_valid_q;
  logic [SAMPLE_W-1:0]      out_data_q;

  // shared units
  logic                mul_en;
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic                div_start;
  logic [DVD_W-1:0]    div_dvd;
  logic [DEN_W-1:0]    div_den;
  osc_div_stat_t       div_stat;
  logic [DVD_W-1:0]    div_quot;

  osc_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  osc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_MQ_LO: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, mag_q[31:0]};
        mul_b  = MUL_W'(coef_q);
      end
      ST_MQ_HI: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(mag_q[OPND_W-1:32]);
        mul_b  = MUL_W'(coef_q);
      end
      ST_SH_MUL1: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(u_q);
        mul_b  = acc_q;
      end
      ST_SH_MUL2: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(mul_p[61:32]);
        mul_b  = recip(k_q);
      end
      ST_SH_SQ1: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, acc_q[31:0]};
        mul_b  = {1'b0, acc_q[31:0]};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // rounded magnitude of a coefficient product
  logic [82:0] mq_full;
  always_comb begin
    mq_full = 83'(lo_q) + {mul_p[50:0], 32'b0}
            + (sh16_q ? 83'd32768 : 83'd8388608);
  end

  // Horner divide-by-k with one correction step
  logic [29:0]      hq0;
  logic [32:0]      hqk;
  logic [32:0]      hrem;
  logic [29:0]      hq;
  logic [DEN_W-1:0] hacc;
  always_comb begin
    hq0  = mul_p[61:32];
    hqk  = 33'(hq0) * 33'(k_q);
    hrem = 33'(t_q) - hqk;
    hq   = (hrem >= 33'(k_q)) ? hq0 + 30'd1 : hq0;
    hacc = ONE_Q32 - DEN_W'(hq);
  end

  // squaring step, rounded half up
  logic [PROD_W:0] sq_sum;
  assign sq_sum = {1'b0, mul_p} + 67'd2147483648;

  // divider operands: d * 2^32 + den / 2 over den
  always_comb begin
    div_start = (state_q == ST_SH_DST);
    div_den   = ONE_Q32 - acc_q;
    div_dvd   = {1'b0, d_q[17:0], 32'b0} + DVD_W'(div_den[DEN_W-1:1]);
  end

  // output rounding and saturation
  logic [LPO_W-1:0]    out_mag;
  logic [40:0]         out_rnd;
  logic [30:0]         out_sat;
  logic [SAMPLE_W-1:0] out_val;
  always_comb begin
    out_mag = lpo_q[LPO_W-1] ? LPO_W'(-lpo_q) : LPO_W'(lpo_q);
    out_rnd = 41'((57'(out_mag) + 57'd32768) >> FRAC_W);
    out_sat = (out_rnd > 41'(OUT_MAX)) ? OUT_MAX : out_rnd[30:0];
    out_val = lpo_q[LPO_W-1] ? -{1'b0, out_sat} : {1'b0, out_sat};
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      lp_in_q     <= RST_LP_IN;
      hp_in_q     <= RST_HP_IN;
      lp_out_q    <= RST_LP_OUT;
      gain_q      <= RST_GAIN;
      knee_q      <= RST_KNEE;
      offset_q    <= RST_OFFSET;
      lpm_q       <= '0;
      hpi_q       <= '0;
      hpo_q       <= '0;
      lpo_q       <= '0;
      opnd_q      <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      coef_q      <= '0;
      sh16_q      <= 1'b0;
      lo_q        <= '0;
      rmag_q      <= '0;
      r_q         <= '0;
      d_q         <= '0;
      shp_q       <= '0;
      cl_q        <= '0;
      u_q         <= '0;
      acc_q       <= '0;
      t_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // config writes
      if (cfg_valid_i) begin
        case (osc_reg_e'(cfg_index_i))
          REG_LP_IN:  lp_in_q  <= cfg_data_i;
          REG_HP_IN:  hp_in_q  <= cfg_data_i;
          REG_LP_OUT: lp_out_q <= cfg_data_i;
          REG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
          REG_KNEE:   knee_q   <= $signed(cfg_data_i[GAIN_W-1:0]);
          REG_OFFSET: offset_q <= $signed(cfg_data_i[GAIN_W-1:0]);
          default: ;
        endcase
      end

      // output register: load a finished result or hand off the waiting one
      if ((state_q == ST_OUT) && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
        out_data_q  <= out_val;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            opnd_q  <= OPND_W'($signed({s_axis_tdata, 16'b0})) - OPND_W'(lpm_q);
            coef_q  <= lp_in_q;
            sh16_q  <= 1'b0;
            ret_q   <= ST_LP1;
            state_q <= ST_MQ_ABS;
          end
        end
        // coefficient product: magnitude, two partial products, round, sign
        ST_MQ_ABS: begin
          mag_q   <= opnd_q[OPND_W-1] ? OPND_W'(-opnd_q) : OPND_W'(opnd_q);
          neg_q   <= opnd_q[OPND_W-1];
          state_q <= ST_MQ_LO;
        end
        ST_MQ_LO: begin
          state_q <= ST_MQ_HI;
        end
        ST_MQ_HI: begin
          lo_q    <= mul_p[OPND_W-1:0];
          state_q <= ST_MQ_SUM;
        end
        ST_MQ_SUM: begin
          rmag_q  <= sh16_q ? mq_full[82:16] : RMAG_W'(mq_full[82:24]);
          state_q <= ST_MQ_SIGN;
        end
        ST_MQ_SIGN: begin
          r_q     <= neg_q ? -$signed({1'b0, rmag_q}) : $signed({1'b0, rmag_q});
          state_q <= ret_q;
        end
        // input lowpass
        ST_LP1: begin
          lpm_q   <= LPI_W'(sat_wide(WIDE_W'(lpm_q) + WIDE_W'(r_q), LPI_W));
          state_q <= ST_HP0;
        end
        // input highpass
        ST_HP0: begin
          opnd_q  <= OPND_W'(hpo_q) + OPND_W'(lpm_q) - OPND_W'(hpi_q);
          hpi_q   <= lpm_q;
          coef_q  <= hp_in_q;
          sh16_q  <= 1'b0;
          ret_q   <= ST_HP1;
          state_q <= ST_MQ_ABS;
        end
        ST_HP1: begin
          hpo_q   <= HPO_W'(sat_wide(WIDE_W'(r_q), HPO_W));
          state_q <= ST_G0;
        end
        // pre-gain and knee
        ST_G0: begin
          opnd_q  <= OPND_W'(hpo_q);
          coef_q  <= COEF_W'(gain_q);
          sh16_q  <= 1'b1;
          ret_q   <= ST_G1;
          state_q <= ST_MQ_ABS;
        end
        ST_G1: begin
          d_q     <= OPND_W'(sat_wide(WIDE_W'(r_q), LPO_W)) - OPND_W'(knee_q);
          state_q <= ST_D0;
        end
        ST_D0: begin
          if (d_q >= SHAPE_LIM) begin
            shp_q   <= OPND_W'(d_q);
            state_q <= ST_CL0;
          end else if (d_q > 57'sd0) begin
            state_q <= ST_SH_INIT;
          end else begin
            shp_q   <= '0;
            state_q <= ST_CL0;
          end
        end
        // exp(-8d) by a Horner series then eight squarings
        ST_SH_INIT: begin
          u_q     <= {d_q[17:0], 11'b0};
          acc_q   <= ONE_Q32;
          k_q     <= 3'd6;
          state_q <= ST_SH_MUL1;
        end
        ST_SH_MUL1: begin
          state_q <= ST_SH_MUL2;
        end
        ST_SH_MUL2: begin
          t_q     <= mul_p[61:32];
          state_q <= ST_SH_DIV;
        end
        ST_SH_DIV: begin
          if (k_q == 3'd1) begin
            acc_q   <= (hacc > MAX_Q32) ? MAX_Q32 : hacc;
            i_q     <= '0;
            state_q <= ST_SH_SQ1;
          end else begin
            acc_q   <= hacc;
            k_q     <= k_q - 3'd1;
            state_q <= ST_SH_MUL1;
          end
        end
        ST_SH_SQ1: begin
          state_q <= ST_SH_SQ2;
        end
        ST_SH_SQ2: begin
          acc_q <= sq_sum[64:32];
          i_q   <= i_q + 3'd1;
          state_q <= (i_q == 3'd7) ? ST_SH_DST : ST_SH_SQ1;
        end
        // d / (1 - e) on the divider
        ST_SH_DST: begin
          state_q <= ST_SH_DW;
        end
        ST_SH_DW: begin
          if (div_stat.done && !div_stat.busy) begin
            shp_q   <= OPND_W'(div_quot);
            state_q <= ST_CL0;
          end
        end
        // clip output and output lowpass
        ST_CL0: begin
          cl_q    <= LPO_W'(sat_wide(WIDE_W'(offset_q) + WIDE_W'($signed({1'b0, shp_q})),
                                     LPO_W));
          state_q <= ST_CL1;
        end
        ST_CL1: begin
          opnd_q  <= OPND_W'(cl_q) - OPND_W'(lpo_q);
          coef_q  <= lp_out_q;
          sh16_q  <= 1'b0;
          ret_q   <= ST_LO1;
          state_q <= ST_MQ_ABS;
        end
        ST_LO1: begin
          lpo_q   <= LPO_W'(sat_wide(WIDE_W'(lpo_q) + WIDE_W'(r_q), LPO_W));
          state_q <= ST_OUT;
        end
        // wait for the output register to free up
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/osc_checker.sv */
// Port-level checks for the overdrive soft clip core, bound to the top level.
// Depends on osc_pkg.
module osc_checker import osc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [SAMPLE_W-1:0]  m_axis_tdata
);

  // saturation never yields the most negative code
  a_out_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata != 32'h80000000))
    else $error("result outside +-2147483647");

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // the core is not ready in the cycle after taking a sample
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sample accepted while busy");

  // a new result only appears at the end of a sample's processing
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a sample in flight");

endmodule

bind overdrive_soft_clip_filter_core osc_checker u_osc_checker (.*);

/* test/overdrive_soft_clip_filter_core_tb.sv */
// Self-checking testbench for overdrive_soft_clip_filter_core.
// A directed sample table, then random samples under several coefficient sets,
// each checked against a fixed-point predictor of the filter chain. Needs osc_pkg.
`timescale 1ns / 100ps

module overdrive_soft_clip_filter_core_tb;
  import osc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned RANDOM_ITEMS = 680;
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam logic [63:0] ONE_Q32      = 64'd1 << 32;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;
  localparam logic [COEF_W-1:0] COEF_UNITY = 25'd16777216;
  localparam logic [COEF_W-1:0] COEF_MAX   = 25'h1FFFFFF;

  // Setup done before a table row
  typedef enum logic [1:0] {
    SETUP_KEEP,
    SETUP_HOLD_HI,
    SETUP_HOLD_LO
  } setup_e;

  typedef struct {
    setup_e      setup;
    logic [31:0] sample;
    bit          known;
    logic [31:0] result;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COEF_W-1:0] cfg_data_i = '0;

  overdrive_soft_clip_filter_core i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of coefficients and filter state
  logic [COEF_W-1:0] coef_lp_in, coef_hp_in, coef_lp_out;
  logic [GAIN_W-1:0] coef_gain, coef_knee, coef_offset;
  longint lpi_mem, hp_prev_in, hp_prev_out, lpo_mem;

  logic [31:0] sample_queue[$];
  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned n_sent = 0;
  int unsigned n_cfg = 0;
  int unsigned n_cycles = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;

  function automatic longint clamp_signed(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Coefficient product rounded half up on the magnitude, sign reapplied
  function automatic longint scale_round(longint a, logic [63:0] c, int sh);
    logic neg;
    logic [63:0] mag, ah, al, r;
    neg = a < 0;
    mag = neg ? 64'(-a) : 64'(a);
    ah = mag >> sh;
    al = mag & ((64'd1 << sh) - 64'd1);
    r = ah * c + ((al * c + (64'd1 << (sh - 1))) >> sh);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Soft clip curve d / (1 - exp(-8d)) in Q.16
  function automatic longint soft_curve(longint d);
    logic [63:0] u, acc, den, num;
    if (d >= (longint'(1) <<< 18)) return d;
    u = 64'(d) << 11;
    acc = ONE_Q32;
    for (int k = 6; k >= 1; k--) begin
      acc = ONE_Q32 - ((u * acc) >> 32) / 64'(k);
    end
    if (acc > ONE_Q32 - 64'd1) acc = ONE_Q32 - 64'd1;
    for (int i = 0; i < 8; i++) begin
      acc = (acc * acc + (64'd1 << 31)) >> 32;
    end
    den = ONE_Q32 - acc;
    num = 64'(d) << 32;
    return longint'((num + den / 64'd2) / den);
  endfunction

  function automatic void reset_predictor();
    coef_lp_in = RST_LP_IN;
    coef_hp_in = RST_HP_IN;
    coef_lp_out = RST_LP_OUT;
    coef_gain = RST_GAIN;
    coef_knee = RST_KNEE;
    coef_offset = RST_OFFSET;
    lpi_mem = 0;
    hp_prev_in = 0;
    hp_prev_out = 0;
    lpo_mem = 0;
  endfunction

  function automatic void apply_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    case (idx)
      REG_LP_IN:  coef_lp_in = val;
      REG_HP_IN:  coef_hp_in = val;
      REG_LP_OUT: coef_lp_out = val;
      REG_GAIN:   coef_gain = val[GAIN_W-1:0];
      REG_KNEE:   coef_knee = val[GAIN_W-1:0];
      REG_OFFSET: coef_offset = val[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // Runs one sample through the filter chain and updates the state
  function automatic logic [31:0] overdrive_sample(logic [31:0] s);
    longint x, lp, hp, g, d, cl, y;
    logic neg;
    logic [63:0] mag;
    x = longint'($signed(s)) * 65536;
    lp = clamp_signed(lpi_mem + scale_round(x - lpi_mem, 64'(coef_lp_in), 24), LPI_W);
    lpi_mem = lp;
    hp = clamp_signed(scale_round(hp_prev_out + lp - hp_prev_in, 64'(coef_hp_in), 24), HPO_W);
    hp_prev_out = hp;
    hp_prev_in = lp;
    g = clamp_signed(scale_round(hp, 64'(coef_gain), 16), LPO_W);
    d = g - longint'($signed(coef_knee));
    cl = longint'($signed(coef_offset));
    if (d >= 1) cl += soft_curve(d);
    cl = clamp_signed(cl, LPO_W);
    lpo_mem = clamp_signed(lpo_mem + scale_round(cl - lpo_mem, 64'(coef_lp_out), 24), LPO_W);
    neg = lpo_mem < 0;
    mag = neg ? 64'(-lpo_mem) : 64'(lpo_mem);
    mag = (mag + 64'd32768) >> 16;
    if (mag > 64'd2147483647) mag = 64'd2147483647;
    y = neg ? -longint'(mag) : longint'(mag);
    return y[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, $signed(got),
             $signed(want), n_results);
  endtask

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_len(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", n_cycles,
               sample_queue.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check each transaction, then pick the next ready
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sample_queue.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        logic [31:0] want;
        want = sample_queue.pop_front();
        if (m_axis_tdata !== want) report_mismatch("sample_out", m_axis_tdata, want);
      end
      n_results++;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = gap_len(quiet_out);
      m_axis_tready <= (stall_left == 0);
    end
  end

  task automatic wait_idle();
    while (sample_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write, after which cfg_valid_i is dropped again
  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_coef(idx, val);
    n_cfg++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one sample; known results are typed in, others come from the predictor
  task automatic send_sample(logic [31:0] s, bit known, logic [31:0] result);
    int unsigned gap;
    logic [31:0] p;
    gap = gap_len(quiet_in);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    p = overdrive_sample(s);
    sample_queue.push_back(known ? result : p);
    n_sent++;
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return COEF_UNITY;
      2: return COEF_MAX;
      3: return 25'($urandom_range(0, 2000000));
      default: return 25'($urandom_range(0, 16777216));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_signed24();
    case ($urandom_range(0, 5))
      0: return 25'(24'h7FFFFF);
      1: return 25'(24'h800000);
      2: return 25'(24'($urandom));
      default: return 25'(24'($signed(20'($urandom))));
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'($signed(4'($urandom)));
      3, 4:    return 32'($signed(14'($urandom)));
      5:       return 32'($signed(22'($urandom)));
      6:       return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // Directed table: reset coefficients, then held outputs with known results
  stim_row_t stim_table[] = '{
    '{SETUP_KEEP, 32'd0, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'h7FFFFFFF, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'h7FFFFFFF, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'h80000000, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'h80000000, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'hFFFFFFFF, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'd1, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'd0, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'd3, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'hFFFFFFFD, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'd12, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'h55555555, 1'b0, 32'd0},
    '{SETUP_KEEP, 32'hAAAAAAAA, 1'b0, 32'd0},
    // clip input below knee: clip output is the offset, unity output lowpass
    '{SETUP_HOLD_HI, 32'h7FFFFFFF, 1'b1, 32'd128},
    '{SETUP_KEEP, 32'h80000000, 1'b1, 32'd128},
    '{SETUP_KEEP, 32'd0, 1'b1, 32'd128},
    '{SETUP_HOLD_LO, 32'h7FFFFFFF, 1'b1, -32'sd128},
    '{SETUP_KEEP, 32'h80000000, 1'b1, -32'sd128},
    '{SETUP_KEEP, 32'hFFFFFFFF, 1'b1, -32'sd128}
  };

  initial begin
    int unsigned phase_len;
    reset_predictor();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].setup != SETUP_KEEP) begin
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_coef(REG_GAIN, '0);
        write_coef(REG_KNEE, 25'(24'h7FFFFF));
        write_coef(REG_LP_OUT, COEF_UNITY);
        write_coef(REG_OFFSET, (stim_table[i].setup == SETUP_HOLD_HI) ?
                   25'(24'h7FFFFF) : 25'(24'h800000));
      end
      send_sample(stim_table[i].sample, stim_table[i].known, stim_table[i].result);
    end

    // Random phases, each under a fresh coefficient set
    while (n_sent < RANDOM_ITEMS + stim_table.size()) begin
      s_axis_tvalid <= 1'b0;
      wait_idle();
      if ($urandom_range(0, 3) == 0) begin
        write_coef(REG_LP_IN, RST_LP_IN);
        write_coef(REG_HP_IN, RST_HP_IN);
        write_coef(REG_LP_OUT, RST_LP_OUT);
        write_coef(REG_GAIN, 25'(RST_GAIN));
        write_coef(REG_KNEE, 25'(RST_KNEE));
        write_coef(REG_OFFSET, 25'(RST_OFFSET));
      end else begin
        write_coef(REG_LP_IN, pick_coef());
        write_coef(REG_HP_IN, pick_coef());
        write_coef(REG_LP_OUT, pick_coef());
        case ($urandom_range(0, 3))
          0: write_coef(REG_GAIN, '0);
          1: write_coef(REG_GAIN, 25'(24'hFFFFFF));
          default: write_coef(REG_GAIN, 25'($urandom_range(0, 1 << 21)));
        endcase
        write_coef(REG_KNEE, pick_signed24());
        write_coef(REG_OFFSET, pick_signed24());
      end
      // writes to unused indexes must be ignored
      write_coef($urandom_range(0, 1) ? IDX_UNUSED_LO : IDX_UNUSED_HI, 25'($urandom));
      quiet_in = ($urandom_range(0, 4) == 0);
      quiet_out = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) send_sample(pick_sample(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    wait_idle();
    $display("Ran %0d samples and %0d register writes, %0d results checked, %0d cycles",
             n_sent, n_cfg, n_results, n_cycles);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
